// File: src/mctd_pkg.sv
`timescale 1ns / 1ps

package mctd_pkg;

  localparam int unsigned ChWidth    = 3;
  localparam int unsigned TimeWidth  = 32;
  localparam int unsigned DelayWidth = 16;
  localparam logic [DelayWidth-1:0] DelayReset = 16'd50;
  // channel numbers are widened to this before being cut to the address width
  localparam int unsigned ChExtWidth = 7;

  // one channel's stored state
  typedef struct packed {
    logic                 last_sample;
    logic [TimeWidth-1:0] change_time;
    logic                 stable_state;
  } entry_t;

  // one debounced event
  typedef struct packed {
    logic [ChWidth-1:0] channel_res;
    logic               became_occupied;
  } result_t;

  // output queue status
  typedef struct packed {
    logic       full;
    logic [1:0] count;
  } queue_stat_t;

endpackage

// File: src/mctd_if.sv
`timescale 1ns / 1ps

interface mctd_sample_if;
  logic                                valid;
  logic                                ready;
  logic [mctd_pkg::ChWidth-1:0]        channel;
  logic                                occupied;
  logic [mctd_pkg::TimeWidth-1:0]      now_ms;

  modport source (output valid, output channel, output occupied, output now_ms, input ready);
  modport sink (input valid, input channel, input occupied, input now_ms, output ready);
endinterface

interface mctd_event_if;
  logic                         valid;
  logic                         ready;
  logic [mctd_pkg::ChWidth-1:0] channel_res;
  logic                         became_occupied;

  modport source (output valid, output channel_res, output became_occupied, input ready);
  modport sink (input valid, input channel_res, input became_occupied, output ready);
endinterface

// File: src/mctd_state_mem.sv
`timescale 1ns / 1ps

module mctd_state_mem #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output mctd_pkg::entry_t      rd_data,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  mctd_pkg::entry_t      wr_data
);

  mctd_pkg::entry_t mem [DEPTH];
  logic [DEPTH-1:0] written;
  mctd_pkg::entry_t rd_q;
  mctd_pkg::entry_t fwd_data;
  logic             rd_written;
  logic             fwd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // write in the read cycle to the same entry wins over the array
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
      fwd_hit    <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_written <= written[rd_addr];
        fwd_hit    <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data <= wr_data;
    end
  end

  // unwritten entries read as the reset state
  assign rd_data = fwd_hit ? fwd_data : (rd_written ? rd_q : '0);

endmodule

// File: src/mctd_out_queue.sv
`timescale 1ns / 1ps

module mctd_out_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  mctd_pkg::result_t     push_data,
  mctd_event_if.source          events,
  output mctd_pkg::queue_stat_t stat
);

  mctd_pkg::result_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop = events.valid && events.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign events.valid           = (count != 2'd0);
  assign events.channel_res     = slot[rd_ptr].channel_res;
  assign events.became_occupied = slot[rd_ptr].became_occupied;
  assign stat.count             = count;
  assign stat.full              = (count == 2'd2);

endmodule

// File: src/multichannel_time_debouncer.sv
`timescale 1ns / 1ps

// multichannel time debouncer
// samples: one transfer per scanned sample (channel, occupied level, now_ms time).
// events: one transfer per change of a channel's debounced state
//   (channel_res, became_occupied = 1 occupied, 0 released).
// cfg_we / cfg_wdata write debounce_ms; write it only while no sample is in flight.
// a level is adopted once it has been seen unchanged for strictly more than
//   debounce_ms milliseconds (elapsed time taken modulo 2^32).
// a sample that causes an event passes the memory read, then the update stage that
//   pushes it into the queue; it leaves on the events channel behind older events.
// throughput: one sample per cycle while ready is high; the per-channel state
//   lives in one synchronous memory read in the transfer cycle and written back
//   the next, with the pending write forwarded to a read of the same channel.
// reset: all channels free with change time zero, debounce_ms back to 50;
//   per-entry written bits make the memory read as cleared, no clearing pass.
// receiver stall: up to two events queue up; samples keep flowing until the
//   queue plus the sample in the update stage would exceed that, then ready drops.
// samples for channels at or beyond CHANNELS are taken and dropped.
module multichannel_time_debouncer #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  mctd_sample_if.sink                           samples,
  mctd_event_if.source                          events,
  input  logic                                  cfg_we,
  input  logic [mctd_pkg::DelayWidth-1:0]       cfg_wdata
);

  localparam int unsigned AW = $clog2(CHANNELS);

  // configuration
  logic [mctd_pkg::DelayWidth-1:0] debounce_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= mctd_pkg::DelayReset;
    end else if (cfg_we) begin
      debounce_ms <= cfg_wdata;
    end
  end

  // input transfer and memory read address
  logic                                 accept;
  logic [mctd_pkg::ChExtWidth-1:0]      ch_ext;
  logic [AW-1:0]                        rd_addr;
  mctd_pkg::queue_stat_t                qstat;
  logic                                 pop;
  logic [2:0]                           occupancy;
  logic                                 s1_valid;

  assign pop       = events.valid && events.ready;
  // queued events plus the one that may come out of the update stage
  assign occupancy = 3'(qstat.count) + 3'(s1_valid) - 3'(pop);
  assign samples.ready = !rst && (occupancy < 3'd2);
  assign accept    = samples.valid && samples.ready;
  assign ch_ext    = mctd_pkg::ChExtWidth'(samples.channel);
  assign rd_addr   = ch_ext[AW-1:0];

  // update stage registers
  logic [mctd_pkg::ChWidth-1:0]         s1_ch;
  logic                                 s1_level;
  logic [mctd_pkg::TimeWidth-1:0]       s1_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ch    <= samples.channel;
      s1_level <= samples.occupied;
      s1_now   <= samples.now_ms;
    end
  end

  // read-modify-write of the channel entry
  mctd_pkg::entry_t                     entry;
  mctd_pkg::entry_t                     wr_data;
  logic                                 wr_en;
  logic [AW-1:0]                        wr_addr;
  logic [mctd_pkg::ChExtWidth-1:0]      s1_ch_ext;
  logic                                 s1_ok;
  logic [mctd_pkg::TimeWidth-1:0]       elapsed;
  logic                                 push;
  mctd_pkg::result_t                    push_data;

  assign s1_ch_ext = mctd_pkg::ChExtWidth'(s1_ch);
  assign wr_addr   = s1_ch_ext[AW-1:0];
  assign s1_ok     = (32'(s1_ch) < 32'(CHANNELS));
  // modulo 2^32 elapsed time since the last level change
  assign elapsed   = s1_now - entry.change_time;

  always_comb begin
    wr_en   = 1'b0;
    wr_data = entry;
    push    = 1'b0;
    if (s1_valid && s1_ok) begin
      if (entry.last_sample != s1_level) begin
        // level moved: restart the timer
        wr_en               = 1'b1;
        wr_data.last_sample = s1_level;
        wr_data.change_time = s1_now;
      end else if ((elapsed > 32'(debounce_ms)) && (entry.stable_state != s1_level)) begin
        // level held long enough and differs from the debounced state
        wr_en                = 1'b1;
        wr_data.stable_state = s1_level;
        push                 = 1'b1;
      end
    end
  end

  assign push_data.channel_res     = s1_ch;
  assign push_data.became_occupied = s1_level;

  mctd_state_mem #(
    .DEPTH (CHANNELS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (entry),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  mctd_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .events    (events),
    .stat      (qstat)
  );

  // out-of-range channels never write the memory
  a_no_write_bad_channel: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_ok) |-> !wr_en)
    else $error("write for a channel beyond CHANNELS");

  // the event queue never overflows
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!qstat.full || pop))
    else $error("event pushed into a full queue");

  // every event is backed by a write of the new debounced state
  a_event_writes_state: assert property (@(posedge clk) disable iff (rst)
    push |-> (wr_en && (wr_data.stable_state == s1_level) && (entry.stable_state != s1_level)))
    else $error("event without matching state update");

  // a write in the same cycle as a read of that channel is forwarded to that read
  a_fwd_same_channel: assert property (@(posedge clk) disable iff (rst)
    (wr_en && accept && (rd_addr == wr_addr)) |=> (entry == $past(wr_data)))
    else $error("pending write not forwarded to the next read");

endmodule
